@@ hdl/sspc_pkg.sv @@
// ----------------------------------------------------------------------------
// sspc_pkg: shared types and constants of the span occlusion clipper
// Holds operation codes, table geometry and the front-to-back command type.
// ----------------------------------------------------------------------------
package sspc_pkg;

  localparam int MaxRanges = 32;
  localparam int IdxW      = $clog2(MaxRanges);
  localparam int CntW      = $clog2(MaxRanges + 1);
  localparam int ColW      = 12;
  localparam int ResultLimit = 32;
  localparam int EmitW     = $clog2(ResultLimit + 1);

  localparam logic signed [ColW-1:0] NegInf = -12'sd2048;
  localparam logic signed [ColW-1:0] PosInf = 12'sd2047;
  localparam logic [10:0]            ResetWidth = 11'd320;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SOLID = 2'd1,
    OP_PASS  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [9:0]  xs;
    logic [9:0]  xe;
    logic [15:0] tag;
  } cmd_t;

endpackage

@@ hdl/sspc_front.sv @@
// ----------------------------------------------------------------------------
// sspc_front: input stage and command queue
// Accepts items, drops ones that cause nothing, and queues the rest.
// ----------------------------------------------------------------------------
module sspc_front import sspc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_operation,
  input  logic [9:0]  in_x_start,
  input  logic [9:0]  in_x_end,
  input  logic [15:0] in_wall_id,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_take
);

  cmd_t       q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       keep;
  logic       acc;

  // Drop unused codes and reversed spans at entry.
  assign keep = (in_operation == OP_CLEAR) ||
                ((in_operation == OP_SOLID || in_operation == OP_PASS) &&
                 (in_x_end >= in_x_start));
  assign full = (cnt_r == 2'd2);
  assign acc  = push && !full && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, acc} - {1'b0, cmd_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) wr_r <= ~wr_r;
      if (cmd_take) rd_r <= ~rd_r;
    end
    if (acc) q_r[wr_r] <= '{op: op_t'(in_operation), xs: in_x_start, xe: in_x_end,
                           tag: in_wall_id};
  end

endmodule

@@ hdl/sspc_back.sv @@
// ----------------------------------------------------------------------------
// sspc_back: range table sequencer
// Scans the table, emits visible fragments and merges or inserts solid spans; a clear rebuilds the edges.
// ----------------------------------------------------------------------------
module sspc_back import sspc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [10:0] width,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_take,
  output logic        res_valid,
  input  logic        res_take,
  output logic [15:0] res_tag,
  output logic [9:0]  res_first,
  output logic [9:0]  res_last,
  output logic        res_end,
  output logic        res_ovf
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WALK, S_SHIFT, S_DEL, S_DONE
  } state_t;

  state_t state_r;
  logic signed [ColW-1:0] beg_r [MaxRanges];
  logic signed [ColW-1:0] fin_r [MaxRanges];
  logic [CntW-1:0]  cnt_r;
  logic [IdxW-1:0]  i_r, j_r, k_r;
  cmd_t             c_r;
  logic             pend_r;      // fragment pending in the staging slot
  logic [15:0]      ptag_r;
  logic [9:0]       pf_r, pl_r;
  logic             povf_r;
  logic [EmitW-1:0] emitted_r;
  logic             ov_r;
  logic [15:0]      otag_r;
  logic [9:0]       of_r, ol_r;
  logic             oend_r, oovf_r;

  logic signed [ColW-1:0] xs, xe, bi, fi, bj1, fj;
  logic solid, jlast, ilast, stall;
  logic [CntW-1:0] i_ext, j_ext;

  assign xs = {2'b00, c_r.xs};
  assign xe = {2'b00, c_r.xe};
  assign solid = (c_r.op == OP_SOLID);
  assign bi = beg_r[i_r];
  assign fi = fin_r[i_r];
  assign fj = fin_r[j_r];
  assign bj1 = beg_r[j_r + 1'b1];
  assign i_ext = CntW'(i_r);
  assign j_ext = CntW'(j_r);
  assign ilast = (i_ext + 1'b1 >= cnt_r);
  assign jlast = (j_ext + 1'b1 >= cnt_r);

  // Staging slot can hand off to the output register when it is free.
  assign stall = pend_r && ov_r && !res_take;
  assign res_valid = ov_r;
  assign res_tag = otag_r;
  assign res_first = of_r;
  assign res_last = ol_r;
  assign res_end = oend_r;
  assign res_ovf = oovf_r;
  assign cmd_take = (state_r == S_IDLE) && cmd_valid;

  // Stage a fragment: flush any earlier one to the output as non-final.
  task automatic stage(input logic signed [ColW-1:0] f, input logic signed [ColW-1:0] l,
                       input logic o);
    if (f <= l && emitted_r < EmitW'(ResultLimit)) begin
      if (pend_r) begin
        ov_r <= 1'b1;
        otag_r <= ptag_r;
        of_r <= pf_r;
        ol_r <= pl_r;
        oend_r <= 1'b0;
        oovf_r <= povf_r;
      end
      pend_r <= 1'b1;
      ptag_r <= c_r.tag;
      pf_r <= f[9:0];
      pl_r <= l[9:0];
      povf_r <= o;
      emitted_r <= emitted_r + 1'b1;
    end
  endtask

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= CntW'(2);
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
      beg_r[0] <= NegInf;
      fin_r[0] <= -12'sd1;
      beg_r[1] <= {1'b0, ResetWidth};
      fin_r[1] <= PosInf;
    end else begin
      if (ov_r && res_take) ov_r <= 1'b0;
      // Move the staged fragment out; end flag is known once the next one shows
      // up or the item finishes.
      if (!stall) begin
        unique case (state_r)
          S_IDLE: begin
            if (cmd_valid) begin
              c_r <= cmd;
              i_r <= '0;
              emitted_r <= '0;
              if (cmd.op == OP_CLEAR) begin
                beg_r[0] <= NegInf;
                fin_r[0] <= -12'sd1;
                beg_r[1] <= {1'b0, width};
                fin_r[1] <= PosInf;
                cnt_r <= CntW'(2);
              end else begin
                state_r <= S_SCAN;
              end
            end
          end
          S_SCAN: begin
            if (!ilast && fi < xs - 12'sd1) begin
              i_r <= i_r + 1'b1;
            end else begin
              j_r <= i_r;
              if (xs < bi) begin
                if (xe < bi - 12'sd1) begin
                  if (solid && cnt_r >= CntW'(MaxRanges)) begin
                    stage(xs, xe, 1'b1);
                    state_r <= S_DONE;
                  end else begin
                    stage(xs, xe, 1'b0);
                    if (solid) begin
                      k_r <= IdxW'(cnt_r);
                      state_r <= S_SHIFT;
                    end else state_r <= S_DONE;
                  end
                end else begin
                  stage(xs, bi - 12'sd1, 1'b0);
                  if (solid) beg_r[i_r] <= xs;
                  state_r <= (xe <= fi) ? S_DONE : S_WALK;
                end
              end else begin
                state_r <= (xe <= fi) ? S_DONE : S_WALK;
              end
            end
          end
          S_WALK: begin
            if (!jlast && xe >= bj1 - 12'sd1) begin
              stage(fj + 12'sd1, bj1 - 12'sd1, 1'b0);
              j_r <= j_r + 1'b1;
              if (xe <= fin_r[j_r + 1'b1]) begin
                if (solid) begin
                  fin_r[i_r] <= fin_r[j_r + 1'b1];
                  k_r <= i_r + 1'b1;
                  state_r <= S_DEL;
                end else state_r <= S_DONE;
              end
            end else begin
              stage(fj + 12'sd1, xe, 1'b0);
              if (solid) begin
                fin_r[i_r] <= xe;
                k_r <= i_r + 1'b1;
                state_r <= S_DEL;
              end else state_r <= S_DONE;
            end
          end
          S_SHIFT: begin
            // Open a slot at i by moving entries up one per cycle while not stalled.
            if (k_r == i_r) begin
              beg_r[i_r] <= xs;
              fin_r[i_r] <= xe;
              cnt_r <= cnt_r + 1'b1;
              state_r <= S_DONE;
            end else begin
              beg_r[k_r] <= beg_r[k_r - 1'b1];
              fin_r[k_r] <= fin_r[k_r - 1'b1];
              k_r <= k_r - 1'b1;
            end
          end
          S_DEL: begin
            // Compact entries i+1..j out, one move per cycle while not stalled.
            if (CntW'(k_r) + CntW'(j_r - i_r) >= cnt_r) begin
              cnt_r <= cnt_r - CntW'(j_r - i_r);
              state_r <= S_DONE;
            end else begin
              beg_r[k_r] <= beg_r[k_r + (j_r - i_r)];
              fin_r[k_r] <= fin_r[k_r + (j_r - i_r)];
              k_r <= k_r + 1'b1;
            end
          end
          S_DONE: begin
            if (pend_r && !ov_r) begin
              pend_r <= 1'b0;
              ov_r <= 1'b1;
              otag_r <= ptag_r;
              of_r <= pf_r;
              ol_r <= pl_r;
              oend_r <= 1'b1;
              oovf_r <= povf_r;
              state_r <= S_IDLE;
            end else if (!pend_r) begin
              state_r <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

endmodule

@@ hdl/screen_span_occlusion_clipper_core.sv @@
// ----------------------------------------------------------------------------
// screen_span_occlusion_clipper_core: column span occlusion clipper
// Timing: an accepted item passes the front queue; the sequencer then scans past ranges and
// stages each fragment; the final fragment follows the insert or merge via the output register.
// Throughput: the sequencer takes a new item only once back in idle with the last one done, plus
// result stalls; it scans, then moves one entry per cycle on insert or merge while not stalled.
// Reset: synchronous, active low; table returns to the low and high edge ranges using
// screen_width 320; queues empty. A clear item rebuilds the edges from the held screen width.
// ----------------------------------------------------------------------------
module screen_span_occlusion_clipper_core import sspc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_screen_width,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_operation,
  input  logic [9:0]  in_x_start,
  input  logic [9:0]  in_x_end,
  input  logic [15:0] in_wall_id,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_tag_out,
  output logic [9:0]  out_span_first,
  output logic [9:0]  out_span_last,
  output logic        out_last,
  output logic        out_overflow
);

  logic [10:0] width_r;
  logic        cmd_valid, cmd_take, res_valid;
  cmd_t        cmd;

  // Hold the screen width; it takes effect at the next clear.
  always_ff @(posedge clk) begin
    if (!rst_n) width_r <= ResetWidth;
    else if (cfg_we) width_r <= cfg_screen_width;
  end

  sspc_front u_front (
    .clk, .rst_n, .push, .full, .in_operation, .in_x_start, .in_x_end, .in_wall_id,
    .cmd_valid, .cmd, .cmd_take
  );

  sspc_back u_back (
    .clk, .rst_n, .width(width_r), .cmd_valid, .cmd, .cmd_take,
    .res_valid, .res_take(pop),
    .res_tag(out_tag_out), .res_first(out_span_first), .res_last(out_span_last),
    .res_end(out_last), .res_ovf(out_overflow)
  );

  assign empty = !res_valid;

  // A fragment never shows first past last.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_span_first <= out_span_last) else $error("fragment reversed");

  // An overflow fragment is always final; being its item's only fragment is not checked here.
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_overflow) |-> out_last) else $error("overflow not final");

  // A waiting result holds until popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_span_first))) else $error("result lost");

endmodule
